@@ rtl/url_rp_pkg.sv @@
// ----------------------------------------------------------------------------
// url_rp_pkg
// Shared types and codes of the URL reference parser.
// ----------------------------------------------------------------------------
`default_nettype none

package url_rp_pkg;

   localparam logic [15:0] DEFAULT_PORT_RESET = 16'd80;
   localparam logic [15:0] PORT_MAX           = 16'hFFFF;

   // result class tags
   localparam logic [3:0] CLASS_SCHEME   = 4'd0;
   localparam logic [3:0] CLASS_COLON    = 4'd1;
   localparam logic [3:0] CLASS_SLASH1   = 4'd2;
   localparam logic [3:0] CLASS_SLASH2   = 4'd3;
   localparam logic [3:0] CLASS_HOST     = 4'd4;
   localparam logic [3:0] CLASS_BRACKET  = 4'd5;
   localparam logic [3:0] CLASS_PORTCOL  = 4'd6;
   localparam logic [3:0] CLASS_DIGIT    = 4'd7;
   localparam logic [3:0] CLASS_PATH     = 4'd8;
   localparam logic [3:0] CLASS_IGNORED  = 4'd9;
   localparam logic [3:0] CLASS_END      = 4'd10;

   // end status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_EMPTY       = 3'd1;
   localparam logic [2:0] ST_INCOMPLETE  = 3'd2;
   localparam logic [2:0] ST_BAD_LITERAL = 3'd3;
   localparam logic [2:0] ST_BAD_PORT    = 3'd4;
   localparam logic [2:0] ST_NEED_HOST   = 3'd5;
   localparam logic [2:0] ST_BAD_PATH    = 3'd6;

   // scheme kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_HTTP  = 2'd1;
   localparam logic [1:0] KIND_FTP   = 2'd2;
   localparam logic [1:0] KIND_NEWS  = 2'd3;

   // scheme match flag bits
   localparam int FLAG_HTTP = 0;
   localparam int FLAG_FTP  = 1;
   localparam int FLAG_NEWS = 2;

   localparam logic [31:0] WORD_HTTP = "http";
   localparam logic [23:0] WORD_FTP  = "ftp";
   localparam logic [31:0] WORD_NEWS = "news";

   localparam logic [7:0] CHAR_COLON   = ":";
   localparam logic [7:0] CHAR_SLASH   = "/";
   localparam logic [7:0] CHAR_LBRACK  = "[";
   localparam logic [7:0] CHAR_RBRACK  = "]";
   localparam logic [7:0] CHAR_ZERO    = "0";
   localparam logic [7:0] CHAR_NINE    = "9";

   typedef struct packed {
      logic [7:0] ch;
      logic       end_mark;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  char_class;
      logic        done_res;
      logic [2:0]  status;
      logic [15:0] port;
      logic [1:0]  scheme_kind;
   } rsp_payload_type;

   // character of a four-letter scheme word at position idx
   function automatic logic [7:0] word4_char(logic [31:0] word, logic [1:0] idx);
      logic [4:0] sh;
      sh = {~idx, 3'b000};
      return word[sh +: 8];
   endfunction

   // character of "ftp" at position idx (0 to 2)
   function automatic logic [7:0] word3_char(logic [23:0] word, logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = word[23:16];
         2'd1:    c = word[15:8];
         default: c = word[7:0];
      endcase
      return c;
   endfunction

endpackage : url_rp_pkg

`default_nettype wire

@@ rtl/url_rp_parse.sv @@
// ----------------------------------------------------------------------------
// url_rp_parse
// Parse state of one URL and the per-character classify and update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module url_rp_parse (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         step_en,
   input  url_rp_pkg::req_payload_type item,
   input  wire  [15:0]                 default_port,
   output url_rp_pkg::rsp_payload_type result
);
   import url_rp_pkg::*;

   typedef enum logic [3:0] {
      PH_START, PH_SCHEME, PH_AFTERCOLON, PH_SLASH1, PH_HOSTSTART, PH_HOST,
      PH_BRACKET, PH_AFTERBRACKET, PH_PORTSTART, PH_PORT, PH_PATH, PH_ERR
   } phase_type;

   phase_type   phase_ff,   phase_in;
   logic [2:0]  slen_ff,    slen_in;
   logic [2:0]  flags_ff,   flags_in;
   logic [15:0] accum_ff,   accum_in;
   logic        seen_ff,    seen_in;
   logic [2:0]  err_ff,     err_in;

   logic [7:0]  c;
   logic        digit;
   logic        news;
   logic [19:0] port_prod;
   logic [2:0]  end_st;
   logic [3:0]  cls;

   assign c         = item.ch;
   assign digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign news      = flags_ff[FLAG_NEWS];
   assign port_prod = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                      + {16'd0, c[3:0]};

   always_comb begin
      unique case (phase_ff)
         PH_START:                            end_st = ST_EMPTY;
         PH_SCHEME:                           end_st = ST_INCOMPLETE;
         PH_AFTERCOLON:                       end_st = news ? ST_BAD_PATH : ST_NEED_HOST;
         PH_SLASH1:                           end_st = news ? ST_OK : ST_NEED_HOST;
         PH_HOSTSTART, PH_HOST,
         PH_AFTERBRACKET:                     end_st = ST_INCOMPLETE;
         PH_BRACKET:                          end_st = ST_BAD_LITERAL;
         PH_PORTSTART:                        end_st = ST_BAD_PORT;
         PH_PORT:                             end_st = ST_BAD_PATH;
         PH_PATH:                             end_st = ST_OK;
         default:                             end_st = err_ff;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      slen_in  = slen_ff;
      flags_in = flags_ff;
      accum_in = accum_ff;
      seen_in  = seen_ff;
      err_in   = err_ff;
      cls      = CLASS_IGNORED;
      result   = '0;

      if (item.end_mark) begin
         result.char_class = CLASS_END;
         result.done_res   = 1'b1;
         result.status     = end_st;
         result.port       = default_port;
         if (end_st == ST_OK) begin
            if (seen_ff) result.port = accum_ff;
            if (flags_ff[FLAG_HTTP])      result.scheme_kind = KIND_HTTP;
            else if (flags_ff[FLAG_FTP])  result.scheme_kind = KIND_FTP;
            else if (flags_ff[FLAG_NEWS]) result.scheme_kind = KIND_NEWS;
            else                          result.scheme_kind = KIND_OTHER;
         end
         // back to a fresh URL
         phase_in = PH_START;
         slen_in  = '0;
         flags_in = '1;
         accum_in = '0;
         seen_in  = 1'b0;
         err_in   = '0;
      end else begin
         unique case (phase_ff)
            PH_START, PH_SCHEME: begin
               if (c == CHAR_COLON) begin
                  if (slen_ff < 3'd4) begin
                     flags_in[FLAG_HTTP] = 1'b0;
                     flags_in[FLAG_NEWS] = 1'b0;
                  end
                  if (slen_ff < 3'd3) flags_in[FLAG_FTP] = 1'b0;
                  phase_in = PH_AFTERCOLON;
                  cls      = CLASS_COLON;
               end else begin
                  if (slen_ff[2] || c != word4_char(WORD_HTTP, slen_ff[1:0]))
                     flags_in[FLAG_HTTP] = 1'b0;
                  if (slen_ff >= 3'd3 || c != word3_char(WORD_FTP, slen_ff[1:0]))
                     flags_in[FLAG_FTP] = 1'b0;
                  if (slen_ff[2] || c != word4_char(WORD_NEWS, slen_ff[1:0]))
                     flags_in[FLAG_NEWS] = 1'b0;
                  if (slen_ff != 3'd7) slen_in = slen_ff + 3'd1;
                  phase_in = PH_SCHEME;
                  cls      = CLASS_SCHEME;
               end
            end
            PH_AFTERCOLON: begin
               if (c == CHAR_SLASH) begin
                  phase_in = PH_SLASH1;
                  cls      = CLASS_SLASH1;
               end else begin
                  phase_in = PH_ERR;
                  err_in   = news ? ST_BAD_PATH : ST_NEED_HOST;
               end
            end
            PH_SLASH1: begin
               if (c == CHAR_SLASH) begin
                  phase_in = PH_HOSTSTART;
                  cls      = CLASS_SLASH2;
               end else if (news) begin
                  phase_in = PH_PATH;
                  cls      = CLASS_PATH;
               end else begin
                  phase_in = PH_ERR;
                  err_in   = ST_NEED_HOST;
               end
            end
            PH_HOSTSTART, PH_HOST: begin
               if (phase_ff == PH_HOSTSTART && c == CHAR_LBRACK) begin
                  phase_in = PH_BRACKET;
                  cls      = CLASS_HOST;
               end else if (c == CHAR_SLASH) begin
                  phase_in = PH_PATH;
                  cls      = CLASS_PATH;
               end else if (c == CHAR_COLON) begin
                  phase_in = PH_PORTSTART;
                  cls      = CLASS_PORTCOL;
               end else begin
                  phase_in = PH_HOST;
                  cls      = CLASS_HOST;
               end
            end
            PH_BRACKET: begin
               if (c == CHAR_RBRACK) begin
                  phase_in = PH_AFTERBRACKET;
                  cls      = CLASS_BRACKET;
               end else begin
                  cls      = CLASS_HOST;
               end
            end
            PH_AFTERBRACKET: begin
               if (c == CHAR_COLON) begin
                  phase_in = PH_PORTSTART;
                  cls      = CLASS_PORTCOL;
               end else if (c == CHAR_SLASH) begin
                  phase_in = PH_PATH;
                  cls      = CLASS_PATH;
               end else begin
                  phase_in = PH_ERR;
                  err_in   = ST_BAD_PATH;
               end
            end
            PH_PORTSTART, PH_PORT: begin
               if (digit) begin
                  // saturate at the largest port
                  accum_in = (port_prod > {4'd0, PORT_MAX}) ? PORT_MAX : port_prod[15:0];
                  seen_in  = 1'b1;
                  phase_in = PH_PORT;
                  cls      = CLASS_DIGIT;
               end else if (phase_ff == PH_PORTSTART) begin
                  phase_in = PH_ERR;
                  err_in   = ST_BAD_PORT;
               end else if (c == CHAR_SLASH) begin
                  phase_in = PH_PATH;
                  cls      = CLASS_PATH;
               end else begin
                  phase_in = PH_ERR;
                  err_in   = ST_BAD_PATH;
               end
            end
            PH_PATH: begin
               cls = CLASS_PATH;
            end
            default: begin
               cls = CLASS_IGNORED;
            end
         endcase
         result.char_class = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         slen_ff  <= '0;
         flags_ff <= '1;
         accum_ff <= '0;
         seen_ff  <= 1'b0;
         err_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         slen_ff  <= slen_in;
         flags_ff <= flags_in;
         accum_ff <= accum_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
      end
   end

`ifndef ASSERT_OFF
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && item.end_mark |=> phase_ff == PH_START && !seen_ff && err_ff == ST_OK)
      else $error("parse state not cleared after end transaction");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      step_en && !item.end_mark && phase_ff == PH_ERR |=> phase_ff == PH_ERR)
      else $error("error phase left before end transaction");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERR |-> err_ff != ST_OK && err_ff != ST_EMPTY)
      else $error("error phase without an error code");

   a_digit_seen: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PORT |-> seen_ff)
      else $error("port phase without a digit");
`endif

endmodule : url_rp_parse

`default_nettype wire

@@ rtl/url_reference_parser_unit.sv @@
// ----------------------------------------------------------------------------
// url_reference_parser_unit
// Classifies URL characters one per transaction and reports status, port
// and scheme kind on the end-marker transaction.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   ch, end_mark
//   rsp_      out        rsp_valid/rsp_ready   char_class, done_res, status,
//                                              port, scheme_kind
//   csr_      in         csr_wr_en             default_port (16 bits)
//
// One transaction per cycle while rsp_ready does not stall; the input register
// feeds the classify/update logic into the result register.
// Synchronous active-high reset empties both stages, clears the parse state
// and sets default_port to DEFAULT_PORT_INIT (80 by default).
// A stall on rsp_ready holds the result register; the input stage takes one
// more transaction only if it is empty; while it is full, req_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module url_reference_parser_unit #(
   parameter logic [15:0] DEFAULT_PORT_INIT = url_rp_pkg::DEFAULT_PORT_RESET
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  url_rp_pkg::req_payload_type  req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output url_rp_pkg::rsp_payload_type  rsp_payload,
   input  wire                          csr_wr_en,
   input  wire  [15:0]                  csr_wr_data
);
   import url_rp_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic [15:0]     dport_ff;
   logic            advance;
   rsp_payload_type step_result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   url_rp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .item         (in_data_ff),
      .default_port (dport_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         dport_ff     <= DEFAULT_PORT_INIT;
      end else begin
         if (csr_wr_en) dport_ff <= csr_wr_data;
         if (req_ready) in_valid_ff <= req_valid;
         // drop the result once taken unless a new one moves in
         if (advance)        out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_data_ff  <= req_payload;
      if (advance)                out_data_ff <= step_result;
   end

`ifndef ASSERT_OFF
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result transaction changed");

   a_done_class: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff.done_res == (out_data_ff.char_class == CLASS_END))
      else $error("done flag and end class disagree");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.done_res |->
         out_data_ff.status == ST_OK && out_data_ff.port == 16'd0
         && out_data_ff.scheme_kind == KIND_OTHER)
      else $error("character result carries end fields");
`endif

endmodule : url_reference_parser_unit

`default_nettype wire
